### hw/rtl/plca_pkg.sv
// ---------------------------------------------------------------------------
// plca_pkg
// Shared constants and types for the polyline length, centre and area block.
// ---------------------------------------------------------------------------
package plca_pkg;

   localparam int COORD_W      = 16;
   localparam int MAX_VERTICES = 4096;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int LEN_W        = 30;
   localparam int MID_W        = 47;
   localparam int CROSS_W      = 45;
   localparam int AREA_W       = 43;
   localparam int SEG_RAD_W    = 34;
   localparam int RAD_W        = 92;
   localparam int ROOT_W       = 46;
   localparam int REM_W        = 48;
   localparam int ITER_W       = 6;
   localparam int SEG_ITERS    = 17;
   localparam int AREA_ITERS   = 46;
   localparam int DIST_W       = 17;
   localparam int QUO_W        = 17;
   localparam int MUL_W        = 25;
   localparam int PROD_W       = 2 * MUL_W;

   localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
   localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
      logic                      first;
      logic                      keep;
      logic [CNT_W-1:0]          count;
   } vtx_entry_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_SQ,
      ACC_CROSS_ADD,
      ACC_CROSS_SUB,
      ACC_MID,
      ACC_AREA
   } acc_kind_type;

   typedef enum logic [1:0] {
      PART_LOLO,
      PART_LOHI,
      PART_HIHI
   } area_part_type;

   typedef struct packed {
      acc_kind_type  kind;
      logic [1:0]    idx;
      area_part_type part;
   } acc_tag_type;

   typedef struct packed {
      logic              start;
      logic [ITER_W-1:0] iters;
   } sqrt_cmd_type;

endpackage

### hw/rtl/plca_req_if.sv
// ---------------------------------------------------------------------------
// plca_req_if
// Vertex channel: valid/ready with one vertex per beat.
// ---------------------------------------------------------------------------
interface plca_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [plca_pkg::COORD_W-1:0] vertex_x;
   logic signed [plca_pkg::COORD_W-1:0] vertex_y;
   logic signed [plca_pkg::COORD_W-1:0] vertex_z;
   logic                               last_vertex;

   modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
   modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

### hw/rtl/plca_rsp_if.sv
// ---------------------------------------------------------------------------
// plca_rsp_if
// Result channel: valid/ready with one polyline summary per beat.
// ---------------------------------------------------------------------------
interface plca_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [plca_pkg::LEN_W-1:0]          total_length;
   logic signed [plca_pkg::COORD_W-1:0] center_x;
   logic signed [plca_pkg::COORD_W-1:0] center_y;
   logic signed [plca_pkg::COORD_W-1:0] center_z;
   logic [plca_pkg::AREA_W-1:0]         area;
   logic [plca_pkg::CNT_W-1:0]          vertex_count;

   modport source (output valid, total_length, center_x, center_y, center_z, area,
                   vertex_count, input ready);
   modport sink   (input valid, total_length, center_x, center_y, center_z, area,
                   vertex_count, output ready);
endinterface

### hw/rtl/polyline_length_center_area.sv
// ---------------------------------------------------------------------------
// polyline_length_center_area
// 3D polyline total length, length-weighted centre and vector area.
// ---------------------------------------------------------------------------
//  channel   dir  beat contents
//  req_chan  in   vertex_x/y/z (Q12.4), last_vertex
//  rsp_chan  out  total_length, center_x/y/z, area (Q35.8), vertex_count
//  csr_wr_*  in   closed_loop, written with csr_wr_en
//
//  Each vertex is worked in the back end mostly by the 17-step segment
//  square root, which runs beside the cross products after the squared
//  distance sum. The last vertex adds the closing segment, the area
//  products, a 46-step area root and up to three divisions.
//  Synchronous active-high reset; no clearing pass.
//  A two-entry queue lets the front take vertices while the back works,
//  and the result register holds a beat while rsp_chan stalls.
// ---------------------------------------------------------------------------
module polyline_length_center_area (
   input  logic       clock,
   input  logic       reset,
   plca_req_if.sink   req_chan,
   plca_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import plca_pkg::*;

   // closed_loop control register, sampled by the back end at the close
   logic closed_ff;

   vtx_entry_type push_entry, pop_entry;
   logic          push_valid, push_ready, pop_valid, pop;
   sqrt_cmd_type  sq_cmd;
   logic [RAD_W-1:0]  sq_rad;
   logic              sq_busy;
   logic [ROOT_W-1:0] sq_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 1'b0;
      end else if (csr_wr_en) begin
         closed_ff <= csr_wr_data;
      end
   end

   // front: takes beats, counts vertices, marks first and overflow vertices
   plca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   plca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop        (pop)
   );

   // shared root unit: segment lengths and the final area magnitude
   plca_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .cmd      (sq_cmd),
      .radicand (sq_rad),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   // back: sums per segment, then closing, area, centre and result beat
   plca_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_entry     (pop_entry),
      .q_valid     (pop_valid),
      .q_pop       (pop),
      .closed_loop (closed_ff),
      .sq_cmd      (sq_cmd),
      .sq_rad      (sq_rad),
      .sq_busy     (sq_busy),
      .sq_root     (sq_root),
      .rsp         (rsp_chan)
   );

endmodule

### hw/rtl/plca_front.sv
// ---------------------------------------------------------------------------
// plca_front
// Accepts vertex beats, tracks the vertex count and tags each entry.
// ---------------------------------------------------------------------------
module plca_front (
   input  logic                    clock,
   input  logic                    reset,
   plca_req_if.sink                req,
   output plca_pkg::vtx_entry_type push_entry,
   output logic                    push_valid,
   input  logic                    push_ready
);
   import plca_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             keep;
   logic             fire;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign fire       = req.valid & push_ready;
   assign keep       = cnt_ff < CNT_W'(MAX_VERTICES);

   always_comb begin
      push_entry.x     = req.vertex_x;
      push_entry.y     = req.vertex_y;
      push_entry.z     = req.vertex_z;
      push_entry.last  = req.last_vertex;
      push_entry.first = (cnt_ff == '0);
      push_entry.keep  = keep;
      push_entry.count = keep ? cnt_ff + 1'b1 : cnt_ff;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (fire) begin
         if (req.last_vertex) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

### hw/rtl/plca_queue.sv
// ---------------------------------------------------------------------------
// plca_queue
// Two-entry queue between the front and back halves.
// ---------------------------------------------------------------------------
module plca_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  plca_pkg::vtx_entry_type push_entry,
   input  logic                    push_valid,
   output logic                    push_ready,
   output plca_pkg::vtx_entry_type pop_entry,
   output logic                    pop_valid,
   input  logic                    pop
);
   import plca_pkg::*;

   vtx_entry_type mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    fill_ff;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

### hw/rtl/plca_isqrt.sv
// ---------------------------------------------------------------------------
// plca_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module plca_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  plca_pkg::sqrt_cmd_type        cmd,
   input  logic [plca_pkg::RAD_W-1:0]    radicand,
   output logic                          busy,
   output logic [plca_pkg::ROOT_W-1:0]   root
);
   import plca_pkg::*;

   logic              busy_ff, busy_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_sh, trial;

   assign busy  = busy_ff;
   assign root  = root_ff;
   // top radicand pair shifted in; trial is 4*root + 1
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.iters;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

### hw/rtl/plca_back.sv
// ---------------------------------------------------------------------------
// plca_back
// Sequencer: segment length, midpoint and cross sums, then area and centre.
// ---------------------------------------------------------------------------
module plca_back (
   input  logic                          clock,
   input  logic                          reset,
   input  plca_pkg::vtx_entry_type       q_entry,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  logic                          closed_loop,
   output plca_pkg::sqrt_cmd_type        sq_cmd,
   output logic [plca_pkg::RAD_W-1:0]    sq_rad,
   input  logic                          sq_busy,
   input  logic [plca_pkg::ROOT_W-1:0]   sq_root,
   plca_rsp_if.source                    rsp
);
   import plca_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CLOSE, S_SQ, S_SQ_END, S_ROOT, S_MID, S_MID_END,
      S_AREA_MUL, S_AREA_END, S_AREA_ROOT, S_DIV_LOAD, S_DIV_ITER, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;

   logic signed [COORD_W-1:0] cur_ff [3], cur_in [3];
   logic signed [COORD_W-1:0] first_ff [3], first_in [3];
   logic signed [COORD_W-1:0] prev_ff [3], prev_in [3];
   logic signed [COORD_W-1:0] center_ff [3], center_in [3];
   logic signed [MID_W-1:0]   mid_ff [3], mid_in [3];
   logic signed [CROSS_W-1:0] cross_ff [3], cross_in [3];
   logic                      last_ff, last_in;
   logic                      closing_ff, closing_in;
   logic                      do_len_ff, do_len_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SEG_RAD_W-1:0]      sq_ff, sq_in;
   logic [DIST_W-1:0]         d_ff, d_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [RAD_W-1:0]          asum_ff, asum_in;
   logic [AREA_W-1:0]         area_ff, area_in;
   logic [1:0]                ax_ff, ax_in;
   area_part_type             part_ff, part_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   acc_tag_type               tag_ff, tag_in;
   logic [MID_W-1:0]          rem_ff, rem_in;
   logic [MID_W-1:0]          dsh_ff, dsh_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]          rsp_len_ff, rsp_len_in;
   logic signed [COORD_W-1:0] rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;
   logic signed [COORD_W-1:0] rsp_cz_ff, rsp_cz_in;
   logic [AREA_W-1:0]         rsp_area_ff, rsp_area_in;
   logic [CNT_W-1:0]          rsp_cnt_ff, rsp_cnt_in;

   logic signed [COORD_W-1:0] opa [3], opb [3];
   logic signed [DIST_W-1:0]  diff [3], summ [3];
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic [CROSS_W-1:0]        cmag;
   logic [MID_W-1:0]          nmag;
   logic                      nneg;
   logic [LEN_W:0]            len_sum;
   logic [LEN_W:0]            den2;
   logic [ROOT_W-2:0]         half_root;
   logic [QUO_W-1:0]          quo_next;
   logic signed [COORD_W-1:0] clamp_q;
   logic [RAD_W-1:0]          area_term;
   logic                      out_free;

   // segment runs prev -> b, where b is the new vertex or, when closing, the first one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         opa[i]  = prev_ff[i];
         opb[i]  = closing_ff ? first_ff[i] : cur_ff[i];
         diff[i] = DIST_W'(opa[i]) - DIST_W'(opb[i]);
         summ[i] = DIST_W'(opa[i]) + DIST_W'(opb[i]);
      end
   end

   assign cmag      = cross_ff[ax_ff][CROSS_W-1] ? CROSS_W'(-cross_ff[ax_ff]) : cross_ff[ax_ff];
   assign nneg      = mid_ff[ax_ff][MID_W-1];
   assign nmag      = nneg ? MID_W'(-mid_ff[ax_ff]) : mid_ff[ax_ff];
   assign den2      = {len_ff, 1'b0};
   assign len_sum   = {1'b0, len_ff} + (LEN_W+1)'(d_ff);
   assign half_root = sq_root[ROOT_W-1:1];
   assign quo_next  = {quo_ff[QUO_W-2:0], (rem_ff >= dsh_ff)};
   assign out_free  = ~rsp_valid_ff | rsp.ready;

   always_comb begin
      if (nneg) begin
         clamp_q = (quo_next > QUO_W'(32768)) ? $signed(16'h8000) : COORD_W'(-quo_next);
      end else begin
         clamp_q = (quo_next > QUO_W'(32767)) ? $signed(16'h7fff) : COORD_W'(quo_next);
      end
   end

   always_comb begin
      case (tag_ff.part)
         PART_LOLO: area_term = RAD_W'(prod_ff[47:0]);
         PART_LOHI: area_term = RAD_W'(prod_ff[47:0]) << 24;
         PART_HIHI: area_term = RAD_W'(prod_ff[47:0]) << 46;
         default:   area_term = '0;
      endcase
   end

   // shared multiplier operand selection and accumulate tag
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      tag_in = '{kind: ACC_NONE, idx: 2'd0, part: PART_LOLO};
      case (state_ff)
         S_SQ: begin
            mul_a      = MUL_W'(diff[step_ff[1:0]]);
            mul_b      = MUL_W'(diff[step_ff[1:0]]);
            tag_in.kind = ACC_SQ;
         end
         S_ROOT: begin
            case (step_ff)
               5'd0: begin
                  mul_a = MUL_W'(opb[1]); mul_b = MUL_W'(opa[2]);
                  tag_in = '{kind: ACC_CROSS_ADD, idx: 2'd0, part: PART_LOLO};
               end
               5'd1: begin
                  mul_a = MUL_W'(opb[2]); mul_b = MUL_W'(opa[1]);
                  tag_in = '{kind: ACC_CROSS_SUB, idx: 2'd0, part: PART_LOLO};
               end
               5'd2: begin
                  mul_a = MUL_W'(opb[2]); mul_b = MUL_W'(opa[0]);
                  tag_in = '{kind: ACC_CROSS_ADD, idx: 2'd1, part: PART_LOLO};
               end
               5'd3: begin
                  mul_a = MUL_W'(opb[0]); mul_b = MUL_W'(opa[2]);
                  tag_in = '{kind: ACC_CROSS_SUB, idx: 2'd1, part: PART_LOLO};
               end
               5'd4: begin
                  mul_a = MUL_W'(opb[0]); mul_b = MUL_W'(opa[1]);
                  tag_in = '{kind: ACC_CROSS_ADD, idx: 2'd2, part: PART_LOLO};
               end
               5'd5: begin
                  mul_a = MUL_W'(opb[1]); mul_b = MUL_W'(opa[0]);
                  tag_in = '{kind: ACC_CROSS_SUB, idx: 2'd2, part: PART_LOLO};
               end
               default: ;
            endcase
         end
         S_MID: begin
            mul_a      = MUL_W'(summ[step_ff[1:0]]);
            mul_b      = {{(MUL_W-DIST_W){1'b0}}, d_ff};
            tag_in.kind = do_len_ff ? ACC_MID : ACC_NONE;
            tag_in.idx  = step_ff[1:0];
         end
         S_AREA_MUL: begin
            tag_in.kind = ACC_AREA;
            tag_in.part = part_ff;
            case (part_ff)
               PART_LOLO: begin
                  mul_a = {2'b00, cmag[22:0]}; mul_b = {2'b00, cmag[22:0]};
               end
               PART_LOHI: begin
                  mul_a = {2'b00, cmag[22:0]}; mul_b = {3'b000, cmag[44:23]};
               end
               PART_HIHI: begin
                  mul_a = {3'b000, cmag[44:23]}; mul_b = {3'b000, cmag[44:23]};
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cur_in     = cur_ff;
      first_in   = first_ff;
      prev_in    = prev_ff;
      center_in  = center_ff;
      mid_in     = mid_ff;
      cross_in   = cross_ff;
      last_in    = last_ff;
      closing_in = closing_ff;
      do_len_in  = do_len_ff;
      count_in   = count_ff;
      sq_in      = sq_ff;
      d_in       = d_ff;
      len_in     = len_ff;
      asum_in    = asum_ff;
      area_in    = area_ff;
      ax_in      = ax_ff;
      part_in    = part_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      quo_in     = quo_ff;
      q_pop      = 1'b0;
      sq_cmd     = '{start: 1'b0, iters: ITER_W'(SEG_ITERS)};
      sq_rad     = {sq_ff, {(RAD_W-SEG_RAD_W){1'b0}}};

      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_len_in   = rsp_len_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_cz_in    = rsp_cz_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cur_in[0]  = q_entry.x;
               cur_in[1]  = q_entry.y;
               cur_in[2]  = q_entry.z;
               last_in    = q_entry.last;
               count_in   = q_entry.count;
               closing_in = 1'b0;
               do_len_in  = 1'b1;
               step_in    = '0;
               sq_in      = '0;
               if (q_entry.keep && q_entry.first) begin
                  first_in[0] = q_entry.x; first_in[1] = q_entry.y; first_in[2] = q_entry.z;
                  prev_in[0]  = q_entry.x; prev_in[1]  = q_entry.y; prev_in[2]  = q_entry.z;
                  state_in    = q_entry.last ? S_CLOSE : S_IDLE;
               end else if (q_entry.keep) begin
                  state_in = S_SQ;
               end else begin
                  state_in = q_entry.last ? S_CLOSE : S_IDLE;
               end
            end
         end
         S_CLOSE: begin
            closing_in = 1'b1;
            do_len_in  = closed_loop && (count_ff > CNT_W'(1));
            step_in    = '0;
            sq_in      = '0;
            state_in   = S_SQ;
         end
         S_SQ: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd2) begin
               state_in = S_SQ_END;
            end
         end
         S_SQ_END: begin
            step_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            sq_cmd.start = (step_ff == 5'd0);
            if (step_ff < 5'd7) begin
               step_in = step_ff + 1'b1;
            end else if (!sq_busy) begin
               d_in     = sq_root[DIST_W-1:0];
               step_in  = '0;
               state_in = S_MID;
            end
         end
         S_MID: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd2) begin
               state_in = S_MID_END;
            end
         end
         S_MID_END: begin
            if (do_len_ff) begin
               len_in = (len_sum > (LEN_W+1)'(LEN_MAX)) ? LEN_MAX : len_sum[LEN_W-1:0];
            end
            if (closing_ff) begin
               ax_in    = 2'd0;
               part_in  = PART_LOLO;
               asum_in  = '0;
               state_in = S_AREA_MUL;
            end else begin
               prev_in  = cur_ff;
               state_in = last_ff ? S_CLOSE : S_IDLE;
            end
         end
         S_AREA_MUL: begin
            case (part_ff)
               PART_LOLO: part_in = PART_LOHI;
               PART_LOHI: part_in = PART_HIHI;
               default: begin
                  part_in = PART_LOLO;
                  if (ax_ff == 2'd2) begin
                     state_in = S_AREA_END;
                  end else begin
                     ax_in = ax_ff + 1'b1;
                  end
               end
            endcase
         end
         S_AREA_END: begin
            step_in  = '0;
            state_in = S_AREA_ROOT;
         end
         S_AREA_ROOT: begin
            sq_cmd.start = (step_ff == 5'd0);
            sq_cmd.iters = ITER_W'(AREA_ITERS);
            sq_rad       = asum_ff;
            if (step_ff == 5'd0) begin
               step_in = 5'd1;
            end else if (!sq_busy) begin
               area_in  = (half_root > (ROOT_W-1)'(AREA_MAX)) ? AREA_MAX
                                                               : half_root[AREA_W-1:0];
               ax_in    = 2'd0;
               state_in = S_DIV_LOAD;
            end
         end
         S_DIV_LOAD: begin
            if (count_ff == CNT_W'(1)) begin
               center_in[ax_ff] = first_ff[ax_ff];
            end else if (len_ff == '0) begin
               center_in[ax_ff] = '0;
            end else if ({1'b0, nmag} >= {den2, {QUO_W{1'b0}}}) begin
               center_in[ax_ff] = nneg ? $signed(16'h8000) : $signed(16'h7fff);
            end else begin
               rem_in  = nmag;
               dsh_in  = {den2, {(QUO_W-1){1'b0}}};
               quo_in  = '0;
               step_in = '0;
            end
            if ((count_ff != CNT_W'(1)) && (len_ff != '0) &&
                ({1'b0, nmag} < {den2, {QUO_W{1'b0}}})) begin
               state_in = S_DIV_ITER;
            end else if (ax_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               ax_in = ax_ff + 1'b1;
            end
         end
         S_DIV_ITER: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
            end
            quo_in  = quo_next;
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(QUO_W - 1)) begin
               center_in[ax_ff] = clamp_q;
               if (ax_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  ax_in    = ax_ff + 1'b1;
                  state_in = S_DIV_LOAD;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = len_ff;
               rsp_cx_in    = center_ff[0];
               rsp_cy_in    = center_ff[1];
               rsp_cz_in    = center_ff[2];
               rsp_area_in  = area_ff;
               rsp_cnt_in   = count_ff;
               len_in       = '0;
               for (int i = 0; i < 3; i++) begin
                  first_in[i] = '0;
                  prev_in[i]  = '0;
                  mid_in[i]   = '0;
                  cross_in[i] = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // product accumulate from the registered product, in the cycle after the multiply
      case (tag_ff.kind)
         ACC_SQ:        sq_in = sq_ff + prod_ff[SEG_RAD_W-1:0];
         ACC_CROSS_ADD: cross_in[tag_ff.idx] = cross_ff[tag_ff.idx] + prod_ff[CROSS_W-1:0];
         ACC_CROSS_SUB: cross_in[tag_ff.idx] = cross_ff[tag_ff.idx] - prod_ff[CROSS_W-1:0];
         ACC_MID:       mid_in[tag_ff.idx] = mid_ff[tag_ff.idx] + prod_ff[MID_W-1:0];
         ACC_AREA:      asum_in = asum_ff + area_term;
         default: ;
      endcase
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.total_length = rsp_len_ff;
   assign rsp.center_x     = rsp_cx_ff;
   assign rsp.center_y     = rsp_cy_ff;
   assign rsp.center_z     = rsp_cz_ff;
   assign rsp.area         = rsp_area_ff;
   assign rsp.vertex_count = rsp_cnt_ff;

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      center_ff   <= center_in;
      last_ff     <= last_in;
      closing_ff  <= closing_in;
      do_len_ff   <= do_len_in;
      count_ff    <= count_in;
      sq_ff       <= sq_in;
      d_ff        <= d_in;
      asum_ff     <= asum_in;
      area_ff     <= area_in;
      ax_ff       <= ax_in;
      part_ff     <= part_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_cx_ff   <= rsp_cx_in;
      rsp_cy_ff   <= rsp_cy_in;
      rsp_cz_ff   <= rsp_cz_in;
      rsp_area_ff <= rsp_area_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         tag_ff       <= '{kind: ACC_NONE, idx: 2'd0, part: PART_LOLO};
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         for (int i = 0; i < 3; i++) begin
            first_ff[i] <= '0;
            prev_ff[i]  <= '0;
            mid_ff[i]   <= '0;
            cross_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         mid_ff       <= mid_in;
         cross_ff     <= cross_in;
      end
   end

   a_root_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      sq_cmd.start |-> !sq_busy)
      else $error("square root started while busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (len_ff == '0 && cross_ff[0] == '0))
      else $error("polyline sums not cleared after result");

endmodule

### sim/polyline_length_center_area_tb.sv
// ---------------------------------------------------------------------------
// polyline_length_center_area_tb
// Self-checking bench: directed vertex table, random polylines in open and
// closed mode, random idling on both channels.
// ---------------------------------------------------------------------------
module polyline_length_center_area_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import plca_pkg::*;

   typedef struct {
      logic [LEN_W-1:0]          len;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [AREA_W-1:0]         area;
      logic [CNT_W-1:0]          cnt;
   } summary_type;

   typedef struct {
      logic                      cl;      // closed_loop wanted for this polyline
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
      logic                      typed;   // expected summary given in the row
      summary_type               exp_sum;
   } vtx_row_type;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   plca_req_if req_chan ();
   plca_rsp_if rsp_chan ();

   polyline_length_center_area dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---- predictor state: mirrors the block's polyline accumulators --------
   longint      first_v[3], prev_v[3], mid_sum[3], cross_acc[3];
   longint      len_sum;
   int          n_vtx;
   logic        closed_mode;
   summary_type summary_q[$];
   int          fails = 0;
   longint      cyc = 0;

   function automatic void expect_summary(summary_type s);
      summary_q.insert(summary_q.size(), s);
   endfunction

   function automatic longint seg_root(longint a[3], longint b[3]);
      longint unsigned s = 0, r = 0, c;
      for (int i = 0; i < 3; i++) s += (a[i] - b[i]) * (a[i] - b[i]);
      for (int k = 31; k >= 0; k--) begin
         c = r | (64'd1 << k);
         if (c * c <= s) r = c;
      end
      return longint'(r);
   endfunction

   function automatic void add_seg(longint a[3], longint b[3]);
      longint d;
      d = seg_root(a, b);
      len_sum += d;
      if (len_sum > longint'(LEN_MAX)) len_sum = longint'(LEN_MAX);
      for (int i = 0; i < 3; i++) mid_sum[i] += (a[i] + b[i]) * d;
   endfunction

   function automatic void add_cross(longint c[3], longint p[3]);
      cross_acc[0] += c[1] * p[2] - c[2] * p[1];
      cross_acc[1] += c[2] * p[0] - c[0] * p[2];
      cross_acc[2] += c[0] * p[1] - c[1] * p[0];
   endfunction

   function automatic void clear_polyline();
      for (int i = 0; i < 3; i++) begin
         first_v[i] = 0; prev_v[i] = 0; mid_sum[i] = 0; cross_acc[i] = 0;
      end
      len_sum = 0;
      n_vtx   = 0;
   endfunction

   // Folds one vertex in; returns 1 with the summary when the polyline ends.
   function automatic bit fold_vertex(logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y,
                                      logic signed [COORD_W-1:0] z,
                                      logic last, output summary_type s);
      longint v[3], c, mag;
      logic [127:0] sq, r, t;
      v[0] = x; v[1] = y; v[2] = z;
      if (n_vtx < MAX_VERTICES) begin
         if (n_vtx == 0) first_v = v;
         else begin
            add_seg(prev_v, v);
            add_cross(v, prev_v);
         end
         prev_v = v;
         n_vtx++;
      end
      if (!last) return 1'b0;
      if (closed_mode && n_vtx > 1) add_seg(prev_v, first_v);
      add_cross(first_v, prev_v);
      s.len = len_sum[LEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
         if (n_vtx == 1) c = first_v[i];
         else if (len_sum == 0) c = 0;
         else begin
            c = mid_sum[i] / (2 * len_sum);   // truncates toward zero
            if (c > 32767) c = 32767;
            if (c < -32768) c = -32768;
         end
         case (i)
            0: s.cx = c[COORD_W-1:0];
            1: s.cy = c[COORD_W-1:0];
            default: s.cz = c[COORD_W-1:0];
         endcase
      end
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         mag = cross_acc[i] < 0 ? -cross_acc[i] : cross_acc[i];
         sq += 128'(mag) * 128'(mag);
      end
      r = '0;
      for (int k = 61; k >= 0; k--) begin
         t = r | (128'd1 << k);
         if (t * t <= sq) r = t;
      end
      r = r >> 1;
      s.area = (r > 128'(AREA_MAX)) ? AREA_MAX : r[AREA_W-1:0];
      s.cnt  = n_vtx[CNT_W-1:0];
      clear_polyline();
      return 1'b1;
   endfunction

   // ---- vertex channel driver --------------------------------------------
   task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z, logic last);
      int gap;
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.vertex_x    <= x;
      req_chan.vertex_y    <= y;
      req_chan.vertex_z    <= z;
      req_chan.last_vertex <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic push_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z, logic last);
      summary_type s;
      send_vertex(x, y, z, last);
      if (fold_vertex(x, y, z, last, s)) expect_summary(s);
   endtask

   // Sender holds off until the block is quiet: used before every csr write.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      wait (summary_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_closed(logic v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      closed_mode = v;
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(bit near);
      if (near) return COORD_W'($signed($urandom_range(2000)) - 1000);
      return COORD_W'($urandom);
   endfunction

   task automatic random_polylines(int n_items);
      int left, len;
      bit near;
      logic signed [COORD_W-1:0] x, y, z;
      left = n_items;
      while (left > 0) begin
         len  = $urandom_range(9) == 0 ? 1 : $urandom_range(12, 2);
         near = 1'($urandom_range(1));
         for (int k = 0; k < len; k++) begin
            // occasional repeated vertex gives a zero-length segment
            if (k == 0 || $urandom_range(7) != 0) begin
               x = rand_coord(near); y = rand_coord(near); z = rand_coord(near);
            end
            push_vertex(x, y, z, k == len - 1);
         end
         left -= len;
      end
   endtask

   // ---- result channel: random stall, check against oldest summary --------
   task automatic check_field(string name, longint e, longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         fails++;
      end
   endtask

   initial begin
      int stall;
      summary_type e;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (summary_q.size() == 0) begin
            $error("result beat with no polyline pending");
            fails++;
         end else begin
            e = summary_q.pop_front();
            check_field("total_length", e.len, rsp_chan.total_length);
            check_field("center_x", e.cx, rsp_chan.center_x);
            check_field("center_y", e.cy, rsp_chan.center_y);
            check_field("center_z", e.cz, rsp_chan.center_z);
            check_field("area", e.area, rsp_chan.area);
            check_field("vertex_count", e.cnt, rsp_chan.vertex_count);
         end
      end
   end

   // ---- watchdog --------------------------------------------------------
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---- directed table: typed rows only where the answer is obvious ------
   function automatic vtx_row_type row(logic cl, int x, int y, int z, logic last,
                                       logic typed = 0, summary_type s = '{default: 0});
      vtx_row_type r;
      r.cl = cl; r.x = COORD_W'(x); r.y = COORD_W'(y); r.z = COORD_W'(z); r.last = last;
      r.typed = typed; r.exp_sum = s;
      return r;
   endfunction

   vtx_row_type vtx_table[$];

   function automatic void add_row(vtx_row_type r);
      vtx_table.insert(vtx_table.size(), r);
   endfunction

   initial begin
      summary_type s;
      logic cl_now;
      bit starts;
      req_chan.valid       = 1'b0;
      req_chan.vertex_x    = '0;
      req_chan.vertex_y    = '0;
      req_chan.vertex_z    = '0;
      req_chan.last_vertex = 1'b0;
      closed_mode = 1'b0;
      clear_polyline();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single vertex: centre is the vertex itself
      add_row(row(0, 32767, -32768, 0, 1, 1, '{0, 32767, -32768, 0, 0, 1}));
      add_row(row(0, -1, 1, -32768, 1, 1, '{0, -1, 1, -32768, 0, 1}));
      // two coincident vertices: zero length, centre forced to origin
      add_row(row(0, 5, 5, 5, 0));
      add_row(row(0, 5, 5, 5, 1, 1, '{0, 0, 0, 0, 0, 2}));
      // body diagonal corner to corner
      add_row(row(0, -32768, -32768, -32768, 0));
      add_row(row(0, 32767, 32767, 32767, 1));
      // open triangle, then the same one closed
      add_row(row(0, 0, 0, 0, 0));
      add_row(row(0, 160, 0, 0, 0));
      add_row(row(0, 0, 160, 0, 1));
      add_row(row(1, 0, 0, 0, 0));
      add_row(row(1, 160, 0, 0, 0));
      add_row(row(1, 0, 160, 0, 1));
      // closed rectangle at the coordinate extremes
      add_row(row(1, -32768, -32768, 32767, 0));
      add_row(row(1, 32767, -32768, 32767, 0));
      add_row(row(1, 32767, 32767, -32768, 0));
      add_row(row(1, -32768, 32767, -32768, 1));
      // closed single vertex: no closing segment
      add_row(row(1, 100, -200, 300, 1, 1, '{0, 100, -200, 300, 0, 1}));

      cl_now = 1'b0;
      starts = 1'b1;
      foreach (vtx_table[i]) begin
         if (starts && vtx_table[i].cl != cl_now) begin
            set_closed(vtx_table[i].cl);
            cl_now = vtx_table[i].cl;
         end
         send_vertex(vtx_table[i].x, vtx_table[i].y, vtx_table[i].z, vtx_table[i].last);
         if (fold_vertex(vtx_table[i].x, vtx_table[i].y, vtx_table[i].z,
                         vtx_table[i].last, s))
            expect_summary(vtx_table[i].typed ? vtx_table[i].exp_sum : s);
         starts = vtx_table[i].last;
      end

      // random phases, alternating loop mode
      random_polylines(130);
      set_closed(1'b0);
      random_polylines(130);
      set_closed(1'b1);
      random_polylines(130);
      set_closed(1'b0);
      random_polylines(20);

      wait_idle();
      if (fails == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/plca_pkg.sv
hw/rtl/plca_req_if.sv
hw/rtl/plca_rsp_if.sv
hw/rtl/plca_front.sv
hw/rtl/plca_queue.sv
hw/rtl/plca_isqrt.sv
hw/rtl/plca_back.sv
hw/rtl/polyline_length_center_area.sv
sim/polyline_length_center_area_tb.sv
